// ===== hw/rtl/led_command_frame_parser_unit_defines.svh =====
// Assertion macros for the LED command frame parser unit.
// Included by the top level; no other dependencies.
`ifndef LED_COMMAND_FRAME_PARSER_UNIT_DEFINES_SVH
`define LED_COMMAND_FRAME_PARSER_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define LCFP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define LCFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/lcfp_pkg.sv =====
// Shared constants and types for the LED command frame parser unit.
// No dependencies.
package lcfp_pkg;

   localparam logic [7:0] BYTE_START = 8'h23;
   localparam logic [7:0] BYTE_END   = 8'h24;
   localparam logic [7:0] BYTE_ABORT = 8'h00;

   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_HDR1 = 2'd1;
   localparam logic [1:0] PH_HDR2 = 2'd2;
   localparam logic [1:0] PH_DATA = 2'd3;

   localparam int unsigned STORE_DEPTH = 4;
   localparam logic [7:0]  SEL_MAX     = 8'd7;

   typedef logic [7:0] byte_type;
   typedef byte_type [STORE_DEPTH-1:0] store_type;

   typedef struct packed {
      logic [4:0] ctrl_first;
      logic [4:0] ctrl_second;
      byte_type   red;
      byte_type   green;
      byte_type   blue;
      logic       color_valid;
   } result_type;

   typedef struct packed {
      byte_type red;
      byte_type green;
      byte_type blue;
      logic     color_valid;
   } color_type;

endpackage

// ===== hw/rtl/led_command_frame_parser_unit.sv =====
// LED command frame parser unit: input register, parser, result register, config register.
// Depends on lcfp_pkg, lcfp_parser and led_command_frame_parser_unit_defines.svh.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | req_rx_byte
//   rsp     | out       | rsp_valid/rsp_ready | rsp_ctrl_first .. rsp_color_valid
//   csr     | in        | csr_valid/csr_ready | csr_led_function_code
//
// One byte beat per cycle unless stalled; the closing beat moves from input to result register.
// Throughput is set by the single parser update per cycle between the two registers.
// A stalled result holds the parser; the input register still takes one beat.
// Synchronous active-high reset returns the parser to hunting, code register to 0.
`include "led_command_frame_parser_unit_defines.svh"

module led_command_frame_parser_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lcfp_pkg::byte_type  req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [4:0]          rsp_ctrl_first,
   output logic [4:0]          rsp_ctrl_second,
   output lcfp_pkg::byte_type  rsp_red,
   output lcfp_pkg::byte_type  rsp_green,
   output lcfp_pkg::byte_type  rsp_blue,
   output logic                rsp_color_valid,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_led_function_code
);
   import lcfp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   byte_type   in_byte_ff, in_byte_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic [2:0] code_ff, code_in;
   logic       advance;
   logic       step;
   logic       res_valid;
   result_type res;

   assign advance   = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   lcfp_parser u_parser (
      .clock             (clock),
      .reset             (reset),
      .step              (step),
      .rx_byte           (in_byte_ff),
      .led_function_code (code_ff),
      .res_valid         (res_valid),
      .res               (res)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      code_in      = code_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      if (step) begin
         out_valid_in = res_valid;
         out_in       = res;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (csr_valid && csr_ready) begin
         code_in = csr_led_function_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         code_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         code_ff      <= code_in;
      end
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_ctrl_first  = out_ff.ctrl_first;
   assign rsp_ctrl_second = out_ff.ctrl_second;
   assign rsp_red         = out_ff.red;
   assign rsp_green       = out_ff.green;
   assign rsp_blue        = out_ff.blue;
   assign rsp_color_valid = out_ff.color_valid;

   `LCFP_ASSERT_NEXT(a_req_captured, req_valid && req_ready, in_valid_ff, "req beat lost")
   `LCFP_ASSERT_NEXT(a_stall_holds_input, in_valid_ff && out_valid_ff && !rsp_ready,
                     in_valid_ff, "input dropped while result stalled")
   `LCFP_ASSERT_SAME(a_invalid_black, rsp_valid && !rsp_color_valid,
                     rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0,
                     "invalid select with nonzero color")

endmodule

// ===== hw/rtl/lcfp_color.sv =====
// Color builder: maps select byte and component bytes to red, green, blue.
// Depends on lcfp_pkg.
module lcfp_color (
   input  lcfp_pkg::store_type store,
   output lcfp_pkg::color_type color
);
   import lcfp_pkg::*;

   logic     sel_ok;
   logic     en_r;
   logic     en_g;
   logic     en_b;
   logic [1:0] blue_idx;

   always_comb begin
      sel_ok   = (store[0] <= SEL_MAX);
      en_r     = store[0][2];
      en_g     = store[0][1];
      en_b     = store[0][0];
      blue_idx = 2'd1 + {1'b0, en_r} + {1'b0, en_g};
      color.color_valid = sel_ok;
      color.red   = (sel_ok && en_r) ? store[1] : '0;
      color.green = (sel_ok && en_g) ? (en_r ? store[2] : store[1]) : '0;
      color.blue  = (sel_ok && en_b) ? store[blue_idx] : '0;
   end

endmodule

// ===== hw/rtl/lcfp_parser.sv =====
// Frame parser state: phase, header fields, payload store; a result per matching frame.
// Depends on lcfp_pkg and lcfp_color.
module lcfp_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  lcfp_pkg::byte_type   rx_byte,
   input  logic [2:0]           led_function_code,
   output logic                 res_valid,
   output lcfp_pkg::result_type res
);
   import lcfp_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [2:0] func_ff, func_in;
   logic [4:0] ctrl1_ff, ctrl1_in;
   logic [4:0] ctrl2_ff, ctrl2_in;
   logic [2:0] count_ff, count_in;
   store_type  store_ff, store_in;
   color_type  color;

   lcfp_color u_color (
      .store (store_ff),
      .color (color)
   );

   always_comb begin
      phase_in  = phase_ff;
      func_in   = func_ff;
      ctrl1_in  = ctrl1_ff;
      ctrl2_in  = ctrl2_ff;
      count_in  = count_ff;
      store_in  = store_ff;
      res_valid = 1'b0;
      if (step) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == BYTE_START) begin
                  count_in = '0;
                  store_in = '0;
                  phase_in = PH_HDR1;
               end
            end
            PH_HDR1: begin
               func_in  = rx_byte[7:5];
               ctrl1_in = rx_byte[4:0];
               phase_in = PH_HDR2;
            end
            PH_HDR2: begin
               ctrl2_in = rx_byte[4:0];
               phase_in = PH_DATA;
            end
            PH_DATA: begin
               priority if (rx_byte == BYTE_ABORT) begin
                  phase_in = PH_HUNT;
               end else if (rx_byte == BYTE_END) begin
                  phase_in  = PH_HUNT;
                  res_valid = (func_ff == led_function_code);
               end else if (count_ff < 3'(STORE_DEPTH)) begin
                  store_in[count_ff[1:0]] = rx_byte;
                  count_in = count_ff + 3'd1;
               end
            end
            default: phase_in = PH_HUNT;
         endcase
      end
      res.ctrl_first  = ctrl1_ff;
      res.ctrl_second = ctrl2_ff;
      res.red         = color.red;
      res.green       = color.green;
      res.blue        = color.blue;
      res.color_valid = color.color_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         func_ff  <= '0;
         ctrl1_ff <= '0;
         ctrl2_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         func_ff  <= func_in;
         ctrl1_ff <= ctrl1_in;
         ctrl2_ff <= ctrl2_in;
      end
      store_ff <= store_in;
   end

endmodule
